// ===== rtl/wbps_pkg.sv =====
// Shared types and constants for the windowed byte pattern search.
// No dependencies; imported by every module of the block.
package wbps_pkg;

  localparam int MAX_PATTERN_DEF  = 16;
  localparam int BUFFER_BYTES_DEF = 65536;

  // Pattern bytes held by the two pattern registers.
  localparam int PAT_BYTES = 16;
  localparam int PAT_W     = 8 * PAT_BYTES;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int PLEN_W    = 5;
  localparam int WIN_W     = 17;
  localparam int POS_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_WINDOW_START   = 3'd3,
    REG_WINDOW_LENGTH  = 3'd4
  } cfg_reg_t;

  // Settings the controller needs for window qualification.
  typedef struct packed {
    logic [PLEN_W-1:0] pattern_length;
    logic [WIN_W-1:0]  window_start;
    logic [WIN_W-1:0]  window_length;
  } win_cfg_t;

  // Outcome of a buffer as it stands after the current item.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_res_t;

endpackage

// ===== rtl/wbps_cell.sv =====
// One history cell: holds one recent byte, hands it to the next cell,
// and compares the byte it takes in against its pattern byte. Uses wbps_pkg.
module wbps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic                      clear,
  input  logic [7:0]                byte_in,
  input  logic [wbps_pkg::PAT_W-1:0]  pattern,
  input  logic [wbps_pkg::PLEN_W-1:0] pattern_length,
  output logic [7:0]                byte_r,
  output logic                      match_ok
);
  import wbps_pkg::*;

  logic [7:0] byte_nxt;
  logic [6:0] pat_idx;
  logic [7:0] pat_sel;
  logic       unused_cell;

  // Cell j pairs with pattern byte (length - 1 - j).
  assign unused_cell = 7'(CELL_IDX) >= 7'(pattern_length);
  assign pat_idx     = 7'(pattern_length) - 7'(CELL_IDX) - 7'd1;
  assign pat_sel     = (pat_idx < 7'(PAT_BYTES)) ? pattern[pat_idx[3:0]*8 +: 8] : 8'd0;
  assign match_ok    = unused_cell || (byte_in == pat_sel);

  always_comb begin
    byte_nxt = byte_r;
    if (shift) begin
      byte_nxt = clear ? 8'd0 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

endmodule

// ===== rtl/wbps_ctrl.sv =====
// Search controller: byte counter, window qualification, match record.
// Uses wbps_pkg.
module wbps_ctrl #(
  parameter int MAX_PATTERN  = wbps_pkg::MAX_PATTERN_DEF,
  parameter int BUFFER_BYTES = wbps_pkg::BUFFER_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   last,
  input  logic                   all_eq,
  input  wbps_pkg::win_cfg_t     cfg,
  output wbps_pkg::search_res_t  res
);
  import wbps_pkg::*;

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int EXT_W = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 2;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] mpos_r, mpos_nxt;

  logic [EXT_W-1:0] k1, plen_x, ws_x, wl_x, p, diff;
  logic             hit;

  assign k1     = EXT_W'(cnt_r) + EXT_W'(1);
  assign plen_x = EXT_W'(cfg.pattern_length);
  assign ws_x   = EXT_W'(cfg.window_start);
  assign wl_x   = EXT_W'(cfg.window_length);
  assign p      = k1 - plen_x;

  // A match may end here only if it lies wholly inside the window.
  assign hit = !done_r && (EXT_W'(cnt_r) < EXT_W'(BUFFER_BYTES)) &&
               (plen_x != '0) && (plen_x <= EXT_W'(MAX_PATTERN)) &&
               (k1 >= plen_x) && (p >= ws_x) &&
               ((wl_x == '0) || (k1 <= ws_x + wl_x)) && all_eq;

  assign done_nxt = done_r || hit;
  assign mpos_nxt = hit ? CNT_W'(p) : mpos_r;
  assign diff     = EXT_W'(mpos_nxt) - ws_x;

  assign res.found    = done_nxt;
  assign res.position = done_nxt ? diff[POS_W-1:0] : '0;

  always_comb begin
    cnt_nxt = cnt_r;
    if (EXT_W'(cnt_r) < EXT_W'(BUFFER_BYTES)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
      mpos_r <= '0;
    end else if (step) begin
      if (last) begin
        cnt_r  <= '0;
        done_r <= 1'b0;
        mpos_r <= '0;
      end else begin
        cnt_r  <= cnt_nxt;
        done_r <= done_nxt;
        mpos_r <= mpos_nxt;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> cnt_r == '0 && !done_r)
    else $error("search state not cleared after final item");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && !(step && last) |=> done_r && $stable(mpos_r))
    else $error("recorded match changed within a buffer");

endmodule

// ===== rtl/windowed_byte_pattern_search.sv =====
// Top level of the windowed byte pattern search: configuration registers,
// the cell chain, the controller and the result register.
// Depends on wbps_pkg, wbps_cell and wbps_ctrl.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   in_text_byte[7:0], in_last_byte
//   out_      output     out_valid/out_stall out_found, out_position[15:0]
//   cfg_      input      cfg_we              cfg_index[2:0], cfg_wdata[63:0]
//
// One item per cycle unless a final item stalls: each byte shifts into the cell
// chain, and it and the held bytes are compared against all pattern bytes in
// the same cycle, so the chain sets the rate. The result of a buffer appears
// in the output register in the cycle after its final item is accepted.
// Reset is synchronous, active low; it clears the history, counter and
// configuration. Non-final items are taken even while a result waits;
// a final item stalls only while the output register holds an untaken result.
module windowed_byte_pattern_search #(
  parameter int MAX_PATTERN  = wbps_pkg::MAX_PATTERN_DEF,
  parameter int BUFFER_BYTES = wbps_pkg::BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [wbps_pkg::POS_W-1:0]    out_position,
  input  logic                          cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]    cfg_wdata
);
  import wbps_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0]  pat_low_r, pat_high_r;
  logic [PLEN_W-1:0] plen_r;
  logic [WIN_W-1:0]  ws_r, wl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      plen_r     <= '0;
      ws_r       <= '0;
      wl_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pat_low_r  <= cfg_wdata;
        REG_PATTERN_HIGH:   pat_high_r <= cfg_wdata;
        REG_PATTERN_LENGTH: plen_r     <= cfg_wdata[PLEN_W-1:0];
        REG_WINDOW_START:   ws_r       <= cfg_wdata[WIN_W-1:0];
        REG_WINDOW_LENGTH:  wl_r       <= cfg_wdata[WIN_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  logic [PAT_W-1:0] pattern;
  assign pattern = {pat_high_r, pat_low_r};

  // Handshake: hold a final item back only while the result slot is busy.
  logic out_valid_r, out_valid_nxt;
  logic out_found_r;
  logic [POS_W-1:0] out_position_r;
  logic in_acc, out_acc;

  assign in_stall = in_last_byte && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  // Cell chain: cell 0 takes the new byte, each cell feeds the next.
  logic [7:0] chain_in [MAX_PATTERN];
  logic [7:0] chain_q  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_ok;

  genvar j;
  generate
    for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
      if (j == 0) begin : g_head
        assign chain_in[j] = in_text_byte;
      end else begin : g_link
        assign chain_in[j] = chain_q[j-1];
      end
      wbps_cell #(.CELL_IDX(j)) u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .shift         (in_acc),
        .clear         (in_last_byte),
        .byte_in       (chain_in[j]),
        .pattern       (pattern),
        .pattern_length(plen_r),
        .byte_r        (chain_q[j]),
        .match_ok      (cell_ok[j])
      );
    end
  endgenerate

  win_cfg_t    win_cfg;
  search_res_t res;

  assign win_cfg.pattern_length = plen_r;
  assign win_cfg.window_start   = ws_r;
  assign win_cfg.window_length  = wl_r;

  wbps_ctrl #(
    .MAX_PATTERN (MAX_PATTERN),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_acc),
    .last  (in_last_byte),
    .all_eq(&cell_ok),
    .cfg   (win_cfg),
    .res   (res)
  );

  // Result register: load on the final item, release when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc && in_last_byte) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last_byte) begin
      out_found_r    <= res.found;
      out_position_r <= res.position;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_byte |=> out_valid_r)
    else $error("final item gave no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(in_acc && in_last_byte))
    else $error("pending result overwritten");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_position_r == '0)
    else $error("not-found result carries a position");

endmodule

// ===== verif/windowed_byte_pattern_search_tb.sv =====
// Self-checking testbench for windowed_byte_pattern_search: directed and random buffers
// against a cycle-free predictor of the match offset, checked result by result.
// Depends on wbps_pkg and the windowed_byte_pattern_search RTL only.
module windowed_byte_pattern_search_tb;
  import wbps_pkg::*;

  localparam int MAX_PAT      = MAX_PATTERN_DEF;
  localparam int BUF_BYTES    = BUFFER_BYTES_DEF;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  // The result register loads in the cycle after the final item; drain() adds this margin.
  localparam int SETTLE       = 4;

  // Indexes past the last register; writes there must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_text_byte = '0;
  logic                 in_last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_found;
  logic [POS_W-1:0]     out_position;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  windowed_byte_pattern_search uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_position (out_position),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers and of the search history.
  // ---------------------------------------------------------------------------
  logic [PAT_W-1:0]  pat_bytes;
  logic [PLEN_W-1:0] pat_len;
  logic [WIN_W-1:0]  win_start;
  logic [WIN_W-1:0]  win_len;

  logic [7:0] history [MAX_PAT];   // newest byte at index 0
  int         taken_count;          // bytes of the current buffer, saturating
  bit         match_seen;
  int         match_offset;         // absolute buffer offset of the first match

  search_res_t pending_results[$];

  int  bytes_sent;
  int  error_count;
  int  cycle_count;
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  hold_asked;
  int  hold_seen;
  int  hold_left;

  task automatic clear_history();
    for (int i = 0; i < MAX_PAT; i++) history[i] = '0;
    taken_count  = 0;
    match_seen   = 1'b0;
    match_offset = 0;
  endtask

  // Advance the predictor by one accepted item; queue the outcome on the
  // final byte of a buffer.
  task automatic track_byte(input logic [7:0] data, input logic is_last);
    int          k;
    int          plen;
    int          pos;
    bit          in_win;
    bit          same;
    search_res_t want;
    k    = taken_count;
    plen = int'(pat_len);
    for (int i = MAX_PAT - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = data;
    // Judge the match that ends at this byte, if it can still count.
    if (!match_seen && k < BUF_BYTES && plen != 0 && plen <= MAX_PAT && k + 1 >= plen) begin
      pos    = k + 1 - plen;
      in_win = pos >= int'(win_start) &&
               (win_len == '0 || k + 1 <= int'(win_start) + int'(win_len));
      if (in_win) begin
        same = 1'b1;
        for (int i = 0; i < plen; i++)
          if (history[plen-1-i] != pat_bytes[8*i +: 8]) same = 1'b0;
        if (same) begin
          match_seen   = 1'b1;
          match_offset = pos;
        end
      end
    end
    if (k < BUF_BYTES) taken_count = k + 1;
    if (is_last) begin
      want.found    = match_seen;
      want.position = match_seen ? POS_W'(match_offset - int'(win_start)) : '0;
      pending_results.push_back(want);
      clear_history();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    search_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected: expected none, actual found=%0d position=%0d",
                 $time, out_found, out_position);
      end else begin
        want = pending_results.pop_front();
        if (out_found !== want.found) begin
          error_count++;
          $display("%0t: found mismatch: expected %0d, actual %0d",
                   $time, want.found, out_found);
        end
        if (out_position !== want.position) begin
          error_count++;
          $display("%0t: position mismatch: expected %0d, actual %0d",
                   $time, want.position, out_position);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("windowed_byte_pattern_search_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers. All of them start and end at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one item, idling first at random; hold the payload until taken.
  task automatic send_item(input logic [7:0] data, input logic is_last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_text_byte = data;
    in_last_byte = is_last;
    do @(posedge clk); while (in_stall);
    track_byte(data, is_last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:    pat_bytes[63:0]   = val;
      REG_PATTERN_HIGH:   pat_bytes[127:64] = val;
      REG_PATTERN_LENGTH: pat_len           = val[PLEN_W-1:0];
      REG_WINDOW_START:   win_start         = val[WIN_W-1:0];
      REG_WINDOW_LENGTH:  win_len           = val[WIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int usable_len();
    return (pat_len >= 1 && pat_len <= MAX_PAT) ? int'(pat_len) : 0;
  endfunction

  // Send one buffer; each byte comes from the pattern with even odds, so that partial
  // matches are common. Plant the whole pattern at plant_at unless negative.
  task automatic send_buffer(input int len, input int plant_at);
    logic [7:0] text_q[$];
    int         plen;
    int         pick_span;
    plen      = usable_len();
    pick_span = (plen == 0) ? 1 : plen;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 1) == 1)
        text_q.push_back(pat_bytes[8*$urandom_range(0, pick_span - 1) +: 8]);
      else
        text_q.push_back(8'($urandom));
    end
    if (plant_at >= 0)
      for (int j = 0; j < plen && plant_at + j < len; j++)
        text_q[plant_at + j] = pat_bytes[8*j +: 8];
    for (int i = 0; i < len; i++) send_item(text_q[i], i == len - 1);
  endtask

  task automatic set_rates(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the pattern is empty, so a buffer gives not found.
  task automatic test_reset_state();
    send_item(8'h00, 1'b1);
    drain();
  endtask

  // Window edges: a match inside a window that ends exactly at the match,
  // then a window shorter than the pattern, then a start past the buffer.
  task automatic test_window_edges();
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_00ff_8001);
    write_reg(REG_PATTERN_HIGH, '1);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    write_reg(REG_WINDOW_START, 64'd1);
    write_reg(REG_WINDOW_LENGTH, 64'd3);
    send_item(8'hff, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hff, 1'b1);
    drain();
    write_reg(REG_WINDOW_LENGTH, 64'd2);
    send_item(8'hff, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hff, 1'b1);
    drain();
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    write_reg(REG_WINDOW_START, 64'd65536);
    write_reg(REG_WINDOW_LENGTH, 64'd65536);
    send_item(8'h01, 1'b1);
    drain();
  endtask

  // Lengths above the pattern store give not found even on an exact byte.
  task automatic test_overlong_pattern();
    write_reg(REG_WINDOW_START, 64'd0);
    write_reg(REG_WINDOW_LENGTH, 64'd0);
    write_reg(REG_PATTERN_LENGTH, 64'd17);
    send_item(8'h01, 1'b1);
    drain();
    write_reg(REG_PATTERN_LENGTH, 64'd31);
    send_item(8'h01, 1'b1);
    drain();
  endtask

  // Writes to unused indexes must leave every register alone.
  task automatic test_spare_index();
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    write_reg(REG_SPARE_FIRST, '1);
    write_reg(REG_SPARE_LAST, '1);
    send_item(8'h01, 1'b1);
    drain();
  endtask

  // Change the pattern halfway through a buffer; the history carries over
  // and the final byte is judged against the new pattern.
  task automatic test_midbuffer_write();
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_4443_4241);
    write_reg(REG_PATTERN_LENGTH, 64'd4);
    send_item(8'h41, 1'b0);
    send_item(8'h42, 1'b0);
    drain();
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_0058_4241);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    send_item(8'h58, 1'b1);
    drain();
  endtask

  // Hold the receiver off while short buffers keep coming, so the result
  // register fills and the input stalls on a final byte; then pause the
  // sender until everything has come back.
  task automatic test_backpressure();
    set_rates(0, 0);
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_3c5a);
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    write_reg(REG_WINDOW_START, 64'd0);
    hold_asked++;
    repeat (12) send_buffer($urandom_range(2, 5), 0);
    drain();
  endtask

  task automatic shuffle_settings();
    logic [CFG_W-1:0] val;
    int               pick;
    if ($urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      val = '1;
      else if (pick == 1) val = '0;
      else                val = {$urandom, $urandom};
      write_reg(REG_PATTERN_LOW, val);
    end
    if ($urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      val = '1;
      else if (pick == 1) val = '0;
      else                val = {$urandom, $urandom};
      write_reg(REG_PATTERN_HIGH, val);
    end
    if ($urandom_range(0, 9) < 8) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      val = 64'd0;
      else if (pick == 1) val = 64'($urandom_range(17, 31));
      else if (pick < 5)  val = 64'd16;
      else                val = 64'($urandom_range(1, 16));
      write_reg(REG_PATTERN_LENGTH, val);
    end
    if ($urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      val = 64'd65536;
      else if (pick == 1) val = 64'd65535;
      else if (pick < 12) val = 64'd0;
      else                val = 64'($urandom_range(1, 20));
      write_reg(REG_WINDOW_START, val);
    end
    if ($urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      val = 64'd65536;
      else if (pick == 1) val = 64'd65535;
      else if (pick < 10) val = 64'd0;
      else                val = 64'($urandom_range(1, 30));
      write_reg(REG_WINDOW_LENGTH, val);
    end
    if ($urandom_range(0, 19) == 0)
      write_reg(CFG_IDX_W'(REG_SPARE_FIRST + $urandom_range(0, 2)), {$urandom, $urandom});
  endtask

  // Random phase: new settings between groups of back-to-back buffers.
  // Most buffers carry a planted pattern, often placed at or after the window start.
  task automatic test_random(input int item_budget);
    int first;
    int len;
    int plen;
    int plant_at;
    first = bytes_sent;
    while (bytes_sent - first < item_budget) begin
      drain();
      shuffle_settings();
      repeat ($urandom_range(1, 4)) begin
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                            : $urandom_range(1, 24);
        plen = usable_len();
        plant_at = -1;
        if (plen != 0 && len >= plen && $urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 1) == 1 && int'(win_start) <= len - plen)
            plant_at = $urandom_range(int'(win_start), len - plen);
          else
            plant_at = $urandom_range(0, len - plen);
        end
        send_buffer(len, plant_at);
      end
    end
    drain();
  endtask

  initial begin
    pat_bytes   = '0;
    pat_len     = '0;
    win_start   = '0;
    win_len     = '0;
    bytes_sent  = 0;
    error_count = 0;
    cycle_count = 0;
    hold_asked  = 0;
    hold_seen   = 0;
    hold_left   = 0;
    clear_history();
    set_rates(10, 10);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_window_edges();
    test_overlong_pattern();
    test_spare_index();
    test_midbuffer_write();
    test_backpressure();
    set_rates(31, 69);
    test_random(RANDOM_ITEMS / 3);
    set_rates(69, 31);
    test_random(RANDOM_ITEMS / 3);
    set_rates(0, 0);
    test_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("windowed_byte_pattern_search_tb: done, clean");
    else
      $display("windowed_byte_pattern_search_tb: done, errors");
    $finish;
  end

endmodule
